// File: rtl/lius_pkg.sv
// Shared widths, register codes, reset values, length limits, saturation values and divider request and response types.
package lius_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IN_LEN_W   = 13;
  localparam int OUT_LEN_W  = 15;
  localparam int POS_W      = 12;  // input index p and N = L-1
  localparam int WHOLE_W    = 18;  // whole part w, may run past p on odd configurations
  localparam int REM_W      = 14;  // remainder r and D = M-1
  localparam int OPOS_W     = 15;  // output index, reaches M itself
  localparam int NUM_W      = 30;  // magnitude of the interpolation numerator
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam int MAX_RESULTS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IN_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 1'd1;

  localparam logic [IN_LEN_W-1:0]  IN_LEN_RST  = 13'd480;
  localparam logic [IN_LEN_W-1:0]  IN_LEN_MIN  = 13'd2;
  localparam logic [IN_LEN_W-1:0]  IN_LEN_MAX  = 13'd4096;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_RST = 15'd1323;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MIN = 15'd2;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = 15'd16384;

  localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_NEG = -16'sh8000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/lius_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lius_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lius_pkg::div_req_t req,
  output lius_pkg::div_rsp_t rsp
);
  import lius_pkg::*;

  localparam int DvdW = NUM_W;
  localparam int DvsW = REM_W;
  localparam int CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] CntLast = CntW'(DvdW - 1);

  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [DvdW-1:0] dvd_r;
  logic [DvsW-1:0] rem_r;
  logic [DvsW-1:0] dvs_r;

  logic [DvsW:0]   shifted;
  logic [DvsW:0]   diff;
  logic            ge;

  assign shifted = {rem_r, dvd_r[DvdW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntLast) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_r <= ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      dvd_r <= {dvd_r[DvdW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/linear_interp_upsampler_stereo.sv
// Linear interpolation upsampler: mono samples in, duplicated stereo samples out.
// Each accepted sample releases up to 16 outputs; an output that equals the current
// sample skips the value division. Each output uses the single 30-step restoring
// divider, once for the interpolated value and once for the next output position,
// and one 16x15 multiplier used twice per value. The input is not ready while a
// sample is being worked on; a finished output waits in the output register while
// the next one is computed.
module linear_interp_upsampler_stereo #(
  parameter int MaxResults = lius_pkg::MAX_RESULTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lius_pkg::SAMPLE_W-1:0]        in_tdata,   // [15:0] sample_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2*lius_pkg::SAMPLE_W-1:0]      out_tdata,  // [15:0] left_sample, [31:16] right_sample
  output logic                                 out_tlast,  // last_of_run
  output logic [0:0]                           out_tuser,  // [0] block_end
  input  logic                                 cfg_we,
  input  logic [lius_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [lius_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lius_pkg::*;

  localparam int CntW = $clog2(MaxResults + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxResults);
  localparam logic [CntW-1:0] CntLast = CntW'(MaxResults - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_VGO   = 4'd4;
  localparam logic [3:0] S_VWAIT = 4'd5;
  localparam logic [3:0] S_PGO   = 4'd6;
  localparam logic [3:0] S_PWAIT = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic [IN_LEN_W-1:0]         in_len_r;
  logic [OUT_LEN_W-1:0]        out_len_r;
  logic signed [SAMPLE_W-1:0]  cur_r, cur_nxt;
  logic signed [SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic [POS_W-1:0]            p_r, p_nxt;
  logic [WHOLE_W-1:0]          w_r, w_nxt;
  logic [REM_W-1:0]            r_r, r_nxt;
  logic [OPOS_W-1:0]           op_r, op_nxt;
  logic                        is_last_r, is_last_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0]  val_r, val_nxt;
  logic                        final_r, final_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic                        neg_r, neg_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]  out_val_r, out_val_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_end_r, out_end_nxt;

  logic [IN_LEN_W-1:0]         len_in;
  logic [OUT_LEN_W-1:0]        len_out;
  logic [POS_W-1:0]            n_len;
  logic [REM_W-1:0]            d_len;
  logic [WHOLE_W-1:0]          p_ext;
  logic                        more;
  logic [OPOS_W-1:0]           op_eff;
  logic                        out_free;
  logic signed [SAMPLE_W-1:0]  mul_a;
  logic signed [REM_W:0]       mul_b;
  logic signed [SAMPLE_W+REM_W:0] prod;
  logic [ACC_W-1:0]            acc_mag;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;

  // clamp the configured lengths into their legal ranges
  always_comb begin
    if (in_len_r < IN_LEN_MIN)      len_in = IN_LEN_MIN;
    else if (in_len_r > IN_LEN_MAX) len_in = IN_LEN_MAX;
    else                            len_in = in_len_r;
    if (out_len_r < OUT_LEN_MIN)      len_out = OUT_LEN_MIN;
    else if (out_len_r > OUT_LEN_MAX) len_out = OUT_LEN_MAX;
    else                              len_out = out_len_r;
  end

  assign n_len = POS_W'(len_in - 1'b1);
  assign d_len = REM_W'(len_out - 1'b1);
  assign p_ext = WHOLE_W'(p_r);

  assign more = (cnt_r < CntMax) && (op_r < len_out) &&
                (is_last_r || (w_r < p_ext) || ((w_r == p_ext) && (r_r == '0)));
  assign op_eff = (is_last_r && (cnt_r == CntLast)) ? OPOS_W'(d_len) : op_r;

  assign out_free = !out_valid_r || out_tready;

  // shared multiplier: previous sample by (D-r), then current sample by r
  assign mul_a = (state_r == S_MUL1) ? prev_r : cur_r;
  assign mul_b = (state_r == S_MUL1) ? $signed({1'b0, REM_W'(d_len - r_r)})
                                     : $signed({1'b0, r_r});
  assign prod  = mul_a * mul_b;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  always_comb begin
    div_req.start    = (state_r == S_VGO) || (state_r == S_PGO);
    div_req.divisor  = d_len;
    div_req.dividend = (state_r == S_VGO) ? acc_mag[NUM_W-1:0]
                                          : NUM_W'({1'b0, r_r} + REM_W'(0) + (REM_W+1)'(n_len));
  end

  lius_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    r_nxt         = r_r;
    op_nxt        = op_r;
    is_last_nxt   = is_last_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    final_nxt     = final_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_nxt     = $signed(in_tdata);
          is_last_nxt = p_r >= n_len;
          cnt_nxt     = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (more) begin
          op_nxt    = op_eff;
          final_nxt = op_eff == OPOS_W'(d_len);
          if ((is_last_r && (op_eff == OPOS_W'(d_len))) || (w_r >= p_ext)) begin
            val_nxt   = cur_r;
            state_nxt = S_PGO;
          end else if ((r_r > d_len) && (prev_r != '0)) begin
            // stale remainder above D: the numerator wraps far out of range
            val_nxt   = prev_r[SAMPLE_W-1] ? SAT_NEG : SAT_POS;
            state_nxt = S_PGO;
          end else begin
            state_nxt = S_MUL1;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL1: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = S_VGO;
      end
      S_VGO: begin
        neg_nxt   = acc_r[ACC_W-1];
        state_nxt = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_rsp.done) begin
          if (neg_r) begin
            if (div_rsp.quot > NUM_W'(32768)) val_nxt = SAT_NEG;
            else                              val_nxt = -$signed(div_rsp.quot[SAMPLE_W-1:0]);
          end else begin
            if (div_rsp.quot > NUM_W'(32767)) val_nxt = SAT_POS;
            else                              val_nxt = $signed(div_rsp.quot[SAMPLE_W-1:0]);
          end
          state_nxt = S_PGO;
        end
      end
      S_PGO: begin
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          w_nxt     = w_r + WHOLE_W'(div_rsp.quot[OPOS_W-1:0]);
          r_nxt     = div_rsp.rem;
          op_nxt    = op_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = val_r;
          out_last_nxt  = !more;
          out_end_nxt   = final_r;
          state_nxt     = S_CHECK;
        end
      end
      S_DONE: begin
        prev_nxt = cur_r;
        if (is_last_r) begin
          p_nxt  = '0;
          w_nxt  = '0;
          r_nxt  = '0;
          op_nxt = '0;
        end else begin
          p_nxt = p_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_len_r    <= IN_LEN_RST;
      out_len_r   <= OUT_LEN_RST;
      prev_r      <= '0;
      p_r         <= '0;
      w_r         <= '0;
      r_r         <= '0;
      op_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      p_r         <= p_nxt;
      w_r         <= w_nxt;
      r_r         <= r_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_IN_LEN:  in_len_r  <= cfg_wdata[IN_LEN_W-1:0];
          REG_OUT_LEN: out_len_r <= cfg_wdata[OUT_LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    is_last_r  <= is_last_nxt;
    cnt_r      <= cnt_nxt;
    val_r      <= val_nxt;
    final_r    <= final_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule

// File: rtl/lius_checker.sv
// Port-level checks for the upsampler, bound to the top level.
module lius_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_stereo_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] == out_tdata[31:16])
    else $error("left and right differ");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request");

  a_block_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("block end not last of run");

endmodule

bind linear_interp_upsampler_stereo lius_checker u_lius_checker (.*);
